/* rtl/vntc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Value noise tile classifier package
// Shared constants, register indexes and the fixed-point blend function.
// ----------------------------------------------------------------------------
package vntc_pkg;

    // Port widths fixed by the field definitions.
    localparam int COORD_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int SLOT_W      = 9;
    localparam int CLASS_W     = 8;
    localparam int HEIGHT_W    = 16;
    localparam int VARIANT_W   = 2;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF = 16;
    localparam int CELL_SIZE_DEF  = 6;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE_SEED = 2'd0,
        CFG_SLOT_COUNT = 2'd1
    } t_cfg_idx;

    // Hash multipliers.
    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MUL_S = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_M = 32'd1274126177;

    localparam logic [31:0] VARIANT_SEED_OFFSET = 32'd9973;

    // Seed contribution of the variant hash after reset (seed of zero).
    localparam logic [63:0] VSEED_PROD_RST = 64'(VARIANT_SEED_OFFSET) * 64'(HASH_MUL_S);
    localparam logic [31:0] VSEED_TERM_RST = VSEED_PROD_RST[31:0];

    localparam logic [SLOT_W-1:0] SLOT_COUNT_RST = 9'd1;
    localparam logic [SLOT_W-1:0] SLOT_COUNT_MAX = 9'd256;

    // Linear blend of p toward q by weight w in Q0.16, rounded half up.
    function automatic logic [15:0] blend(input logic [15:0] p,
                                          input logic [15:0] q,
                                          input logic [15:0] w);
        logic [16:0] w_c;
        logic [33:0] acc;
        w_c = 17'h10000 - {1'b0, w};
        acc = 34'(p) * 34'(w_c) + 34'(q) * 34'(w) + 34'h8000;
        return acc[31:16];
    endfunction

endpackage
`default_nettype wire

/* rtl/value_noise_tile_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Value noise tile classifier
// Seeded 2D value noise with smoothstep easing, a class index and a variant.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                         | Handshake
//  ---------+-----------------------------------------------+----------------------
//  input    | i_tile_x, i_tile_y                            | start high, busy low
//  result   | o_class_index, o_noise_height, o_variant_bits | o_valid, one cycle
//  config   | i_cfg_idx, i_cfg_wdata                        | i_cfg_we, no wait
//
// The datapath is a seven-stage pipeline, so a beat can be accepted in every
// cycle and its result appears on the result ports from the stage 7 registers. The
// longest stage holds one 32 by 32 bit multiply after a four-input add; that
// stage sets the clock. busy is always low: the receiver cannot stall, so the
// pipeline simply advances every cycle. Reset (synchronous, active low) clears
// the stage valid bits and returns the registers to seed zero and one class.
//
// Stage plan:
//   1. mask the coordinates, multiply by the reciprocal of the cell size, and
//      form the coordinate terms of the variant hash.
//   2. finish the division (one correction step) into cell and offset; mix
//      the variant hash.
//   3. multiply the cell coordinates by the hash constants; look up the
//      smoothstep weights; finish the variant bits.
//   4. form the four corner hashes and apply the mixing multiply.
//   5. finish the corner values and blend along x on both rows.
//   6. blend along y into the height.
//   7. scale the height by the class count into the class index.

module value_noise_tile_classifier #(
    parameter int COORD_BITS = vntc_pkg::COORD_BITS_DEF,
    parameter int CELL_SIZE  = vntc_pkg::CELL_SIZE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [vntc_pkg::COORD_W-1:0]    i_tile_x,
    input  wire logic [vntc_pkg::COORD_W-1:0]    i_tile_y,

    output logic                                 o_valid,
    output logic [vntc_pkg::CLASS_W-1:0]         o_class_index,
    output logic [vntc_pkg::HEIGHT_W-1:0]        o_noise_height,
    output logic [vntc_pkg::VARIANT_W-1:0]       o_variant_bits,

    input  wire logic                            i_cfg_we,
    input  wire logic [vntc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [vntc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // Coordinate bits that take part; anything above COORD_BITS is ignored.
    localparam int CW = (COORD_BITS < vntc_pkg::COORD_W) ? COORD_BITS : vntc_pkg::COORD_W;
    // Offset width within a cell.
    localparam int OW = $clog2(CELL_SIZE);

    // Division by the cell size: the quotient estimate floor(x * M / 2^S) is
    // either exact or one short, and one compare and subtract corrects it.
    localparam int DIV_SH = CW + 7;
    localparam logic [63:0] DIV_MUL_FULL = (64'd1 << DIV_SH) / CELL_SIZE;
    localparam logic [DIV_SH-1:0] DIV_MUL = DIV_MUL_FULL[DIV_SH-1:0];
    localparam int PROD_W = CW + DIV_SH;
    localparam logic [CW-1:0] CELL_C = CW'(CELL_SIZE);

    // Smoothstep weight table in Q0.16, one entry for each offset.
    logic [15:0] w_ease_tbl [CELL_SIZE];

    for (genvar g = 0; g < CELL_SIZE; g++) begin : g_ease
        localparam logic [63:0] O_V  = 64'(g);
        localparam logic [63:0] C_V  = 64'(CELL_SIZE);
        localparam logic [63:0] NUM  = 64'd65536 * O_V * O_V * (64'd3 * C_V - 64'd2 * O_V);
        localparam logic [63:0] DEN  = C_V * C_V * C_V;
        localparam logic [63:0] W_V  = (NUM + DEN / 64'd2) / DEN;
        assign w_ease_tbl[g] = (W_V > 64'hFFFF) ? 16'hFFFF : W_V[15:0];
    end

    // ------------------------------------------------------------------
    // Configuration registers. The seed enters the hashes only through its
    // product with the seed multiplier, so those products are stored.
    // ------------------------------------------------------------------
    logic [31:0]               r_seed_term;
    logic [31:0]               r_vseed_term;
    logic [vntc_pkg::SLOT_W-1:0] r_slot_count;
    logic [vntc_pkg::SLOT_W-1:0] n_slot_count;

    // A count of zero acts as one; anything above 256 saturates.
    always_comb begin
        n_slot_count = i_cfg_wdata[vntc_pkg::SLOT_W-1:0];
        if (n_slot_count == '0) begin
            n_slot_count = vntc_pkg::SLOT_COUNT_RST;
        end else if (n_slot_count > vntc_pkg::SLOT_COUNT_MAX) begin
            n_slot_count = vntc_pkg::SLOT_COUNT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_term  <= '0;
            r_vseed_term <= vntc_pkg::VSEED_TERM_RST;
            r_slot_count <= vntc_pkg::SLOT_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vntc_pkg::CFG_NOISE_SEED: begin
                    r_seed_term  <= i_cfg_wdata * vntc_pkg::HASH_MUL_S;
                    r_vseed_term <= (i_cfg_wdata + vntc_pkg::VARIANT_SEED_OFFSET)
                                    * vntc_pkg::HASH_MUL_S;
                end
                vntc_pkg::CFG_SLOT_COUNT: begin
                    r_slot_count <= n_slot_count;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits. Nothing ever stalls, so they just shift.
    // ------------------------------------------------------------------
    logic [5:0] r_vld;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[4:0], start & ~busy};
            o_valid <= r_vld[5];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: masked coordinates, reciprocal products, variant terms.
    // ------------------------------------------------------------------
    logic [CW-1:0]     n_x;
    logic [CW-1:0]     n_y;
    logic [CW-1:0]     r1_x;
    logic [CW-1:0]     r1_y;
    logic [PROD_W-1:0] r1_px;
    logic [PROD_W-1:0] r1_py;
    logic [31:0]       r1_vxa;
    logic [31:0]       r1_vya;

    assign n_x = i_tile_x[CW-1:0];
    assign n_y = i_tile_y[CW-1:0];

    always_ff @(posedge i_clk) begin
        r1_x   <= n_x;
        r1_y   <= n_y;
        r1_px  <= PROD_W'(n_x) * PROD_W'(DIV_MUL);
        r1_py  <= PROD_W'(n_y) * PROD_W'(DIV_MUL);
        r1_vxa <= 32'(n_x) * vntc_pkg::HASH_MUL_X;
        r1_vya <= 32'(n_y) * vntc_pkg::HASH_MUL_Y;
    end

    // ------------------------------------------------------------------
    // Stage 2: cell and offset after correction; variant hash mix.
    // ------------------------------------------------------------------
    logic [CW-1:0] n_qx;
    logic [CW-1:0] n_qy;
    logic [CW-1:0] n_remx;
    logic [CW-1:0] n_remy;
    logic [CW-1:0] n_cx;
    logic [CW-1:0] n_cy;
    logic [CW-1:0] n_ox;
    logic [CW-1:0] n_oy;
    logic [31:0]   n_vh;
    logic [31:0]   n_vhs;

    logic [CW-1:0] r2_cx;
    logic [CW-1:0] r2_cy;
    logic [OW-1:0] r2_ox;
    logic [OW-1:0] r2_oy;
    logic [31:0]   r2_vmix;

    always_comb begin
        n_qx   = r1_px[PROD_W-1:DIV_SH];
        n_qy   = r1_py[PROD_W-1:DIV_SH];
        n_remx = r1_x - CW'(n_qx * CELL_C);
        n_remy = r1_y - CW'(n_qy * CELL_C);
        n_cx   = n_qx;
        n_ox   = n_remx;
        if (n_remx >= CELL_C) begin
            n_cx = n_qx + 1'b1;
            n_ox = n_remx - CELL_C;
        end
        n_cy   = n_qy;
        n_oy   = n_remy;
        if (n_remy >= CELL_C) begin
            n_cy = n_qy + 1'b1;
            n_oy = n_remy - CELL_C;
        end
        n_vh   = r1_vxa + r1_vya + r_vseed_term;
        n_vhs  = n_vh ^ (n_vh >> 13);
    end

    always_ff @(posedge i_clk) begin
        r2_cx   <= n_cx;
        r2_cy   <= n_cy;
        r2_ox   <= n_ox[OW-1:0];
        r2_oy   <= n_oy[OW-1:0];
        r2_vmix <= n_vhs * vntc_pkg::HASH_MUL_M;
    end

    // ------------------------------------------------------------------
    // Stage 3: cell terms of the lattice hash, eased weights, variant bits.
    // ------------------------------------------------------------------
    logic [31:0]                   r3_cxa;
    logic [31:0]                   r3_cyb;
    logic [15:0]                   r3_tx;
    logic [15:0]                   r3_ty;
    logic [vntc_pkg::VARIANT_W-1:0] r3_var;

    always_ff @(posedge i_clk) begin
        r3_cxa <= 32'(r2_cx) * vntc_pkg::HASH_MUL_X;
        r3_cyb <= 32'(r2_cy) * vntc_pkg::HASH_MUL_Y;
        r3_tx  <= w_ease_tbl[r2_ox];
        r3_ty  <= w_ease_tbl[r2_oy];
        r3_var <= r2_vmix[1:0] ^ r2_vmix[17:16];
    end

    // ------------------------------------------------------------------
    // Stage 4: the four corner hashes. Corner bit 0 steps x by one cell and
    // bit 1 steps y; stepping a cell adds the multiplier itself.
    // ------------------------------------------------------------------
    logic [31:0] n_ch  [4];
    logic [31:0] n_chs [4];
    logic [31:0] r4_mix [4];
    logic [15:0] r4_tx;
    logic [15:0] r4_ty;
    logic [vntc_pkg::VARIANT_W-1:0] r4_var;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_ch[i]  = r3_cxa + r3_cyb + r_seed_term
                     + (i[0] ? vntc_pkg::HASH_MUL_X : 32'd0)
                     + (i[1] ? vntc_pkg::HASH_MUL_Y : 32'd0);
            n_chs[i] = n_ch[i] ^ (n_ch[i] >> 13);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r4_mix[i] <= n_chs[i] * vntc_pkg::HASH_MUL_M;
        end
        r4_tx  <= r3_tx;
        r4_ty  <= r3_ty;
        r4_var <= r3_var;
    end

    // ------------------------------------------------------------------
    // Stage 5: corner values (low half of the final xorshift), x blends.
    // ------------------------------------------------------------------
    logic [15:0] n_corner [4];
    logic [15:0] r5_a;
    logic [15:0] r5_b;
    logic [15:0] r5_ty;
    logic [vntc_pkg::VARIANT_W-1:0] r5_var;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_corner[i] = r4_mix[i][15:0] ^ r4_mix[i][31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        r5_a   <= vntc_pkg::blend(n_corner[0], n_corner[1], r4_tx);
        r5_b   <= vntc_pkg::blend(n_corner[2], n_corner[3], r4_tx);
        r5_ty  <= r4_ty;
        r5_var <= r4_var;
    end

    // ------------------------------------------------------------------
    // Stage 6: y blend into the height.
    // ------------------------------------------------------------------
    logic [15:0] r6_h;
    logic [vntc_pkg::VARIANT_W-1:0] r6_var;

    always_ff @(posedge i_clk) begin
        r6_h   <= vntc_pkg::blend(r5_a, r5_b, r5_ty);
        r6_var <= r5_var;
    end

    // ------------------------------------------------------------------
    // Stage 7: class index. The height is below 1.0, so the scaled value
    // always stays under the count and needs no clamp.
    // ------------------------------------------------------------------
    logic [24:0] n_cls_prod;

    assign n_cls_prod = 25'(r6_h) * 25'(r_slot_count);

    always_ff @(posedge i_clk) begin
        o_class_index  <= n_cls_prod[23:16];
        o_noise_height <= r6_h;
        o_variant_bits <= r6_var;
    end

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value noise tile classifier testbench
// Drives tile coordinates through the noise pipeline and checks every result
// beat against a local bit-exact model of the hash, easing and blend math.
// ----------------------------------------------------------------------------
module tb;

    // Widths and codes shared with the block.
    localparam int COORD_W    = vntc_pkg::COORD_W;
    localparam int CFG_IDX_W  = vntc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = vntc_pkg::CFG_DATA_W;
    localparam int SLOT_W     = vntc_pkg::SLOT_W;
    localparam int CLASS_W    = vntc_pkg::CLASS_W;
    localparam int HEIGHT_W   = vntc_pkg::HEIGHT_W;
    localparam int VARIANT_W  = vntc_pkg::VARIANT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED = vntc_pkg::CFG_NOISE_SEED;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = vntc_pkg::CFG_SLOT_COUNT;
    localparam logic [SLOT_W-1:0]    SLOT_COUNT_RST = vntc_pkg::SLOT_COUNT_RST;

    // The block is built with its default geometry. The local model uses the
    // same two values, so both sides split coordinates into the same cells.
    localparam int TILE_COORD_BITS = 16;
    localparam int TILE_CELL       = 6;

    // The head of the block gives a seven-stage pipeline.
    localparam int PIPE_DEPTH = 7;

    // Register indexes past the end of the register list. Writes to them must
    // leave both registers untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    localparam int RAND_PHASES     = 8;
    localparam int TILES_PER_PHASE = 106;
    localparam int IDLE_PCT        = 25;
    localparam int PRINT_CAP       = 100;
    localparam int LIMIT_NS        = 2_000_000;

    // One result beat, field by field.
    typedef struct packed {
        logic [CLASS_W-1:0]   cls;
        logic [HEIGHT_W-1:0]  height;
        logic [VARIANT_W-1:0] variant;
    } t_tile_result;

    // Rows of the directed part: a register write, a tile checked against
    // the model, or a tile whose class index is known by inspection.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TILE,
        ROW_TILE_CLASS
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [CLASS_W-1:0]    cls;
    } t_step_row;

    // ------------------------------------------------------------------------
    // Block inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic [COORD_W-1:0]    i_tile_x    = '0;
    logic [COORD_W-1:0]    i_tile_y    = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    logic                  busy;
    logic                  o_valid;
    logic [CLASS_W-1:0]    o_class_index;
    logic [HEIGHT_W-1:0]   o_noise_height;
    logic [VARIANT_W-1:0]  o_variant_bits;

    // Local copy of the two registers, updated whenever the bench writes one.
    logic [31:0]           seed_shadow  = 32'd0;
    logic [SLOT_W-1:0]     slots_shadow = SLOT_COUNT_RST;

    // Expected result beats, oldest first.
    t_tile_result          pending_tiles[$];
    t_tile_result          head_tile;
    int                    mismatches   = 0;
    int                    idle_pct     = IDLE_PCT;

    value_noise_tile_classifier #(
        .COORD_BITS (TILE_COORD_BITS),
        .CELL_SIZE  (TILE_CELL)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_tile_x       (i_tile_x),
        .i_tile_y       (i_tile_y),
        .o_valid        (o_valid),
        .o_class_index  (o_class_index),
        .o_noise_height (o_noise_height),
        .o_variant_bits (o_variant_bits),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Noise model.
    // ------------------------------------------------------------------------

    // Multiply-xorshift hash of a lattice point. All arithmetic wraps at 32
    // bits, just like the unsigned hash it mirrors.
    function automatic logic [31:0] lattice_hash(input logic [31:0] px,
                                                 input logic [31:0] py,
                                                 input logic [31:0] ps);
        logic [31:0] h;
        h = px * vntc_pkg::HASH_MUL_X + py * vntc_pkg::HASH_MUL_Y
          + ps * vntc_pkg::HASH_MUL_S;
        h = (h ^ (h >> 13)) * vntc_pkg::HASH_MUL_M;
        return h ^ (h >> 16);
    endfunction

    // Smoothstep weight of an in-cell offset, Q0.16, rounded half up and
    // held below one.
    function automatic logic [31:0] ease_q16(input logic [31:0] off);
        longint unsigned c;
        longint unsigned o;
        longint unsigned den;
        longint unsigned w;
        c   = TILE_CELL;
        o   = off;
        den = c * c * c;
        w   = (65536 * o * o * (3 * c - 2 * o) + den / 2) / den;
        if (w > 65535)
            w = 65535;
        return 32'(w);
    endfunction

    // Weighted mix of p toward q, Q0.16, rounded half up.
    function automatic logic [15:0] lerp_q16(input logic [15:0] p,
                                             input logic [15:0] q,
                                             input logic [31:0] w);
        logic [63:0] acc;
        acc = 64'(p) * (64'd65536 - 64'(w)) + 64'(q) * 64'(w) + 64'd32768;
        return acc[31:16];
    endfunction

    // Full result of one tile under the current register copy.
    function automatic t_tile_result predict_tile(input logic [COORD_W-1:0] tx,
                                                  input logic [COORD_W-1:0] ty);
        t_tile_result r;
        logic [31:0]  x;
        logic [31:0]  y;
        logic [31:0]  cx;
        logic [31:0]  cy;
        logic [31:0]  wx;
        logic [31:0]  wy;
        logic [15:0]  v00;
        logic [15:0]  v10;
        logic [15:0]  v01;
        logic [15:0]  v11;
        logic [15:0]  row0;
        logic [15:0]  row1;
        logic [31:0]  count;
        logic [63:0]  scaled;
        x   = 32'(tx) & ((32'd1 << TILE_COORD_BITS) - 32'd1);
        y   = 32'(ty) & ((32'd1 << TILE_COORD_BITS) - 32'd1);
        cx  = x / TILE_CELL;
        cy  = y / TILE_CELL;
        wx  = ease_q16(x % TILE_CELL);
        wy  = ease_q16(y % TILE_CELL);
        v00 = 16'(lattice_hash(cx,         cy,         seed_shadow));
        v10 = 16'(lattice_hash(cx + 32'd1, cy,         seed_shadow));
        v01 = 16'(lattice_hash(cx,         cy + 32'd1, seed_shadow));
        v11 = 16'(lattice_hash(cx + 32'd1, cy + 32'd1, seed_shadow));
        row0     = lerp_q16(v00, v10, wx);
        row1     = lerp_q16(v01, v11, wx);
        r.height = lerp_q16(row0, row1, wy);
        // A class count of zero acts as one; anything above 256 acts as 256.
        count = 32'(slots_shadow);
        if (count == 32'd0)
            count = 32'd1;
        if (count > 32'd256)
            count = 32'd256;
        scaled = (64'(r.height) * 64'(count)) >> 16;
        if (scaled > 64'(count - 32'd1))
            scaled = 64'(count - 32'd1);
        r.cls     = scaled[CLASS_W-1:0];
        r.variant = 2'(lattice_hash(x, y, seed_shadow + vntc_pkg::VARIANT_SEED_OFFSET));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------------

    // Every failure goes through here: one line, and the count goes up. The
    // printout stops after a while so a broken block cannot flood the log.
    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("tb: mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Result beats cannot be held off, so each one is taken at the edge that
    // ends its cycle. Outputs are read before the block updates them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_tiles.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                head_tile = pending_tiles.pop_front();
                if (o_class_index !== head_tile.cls)
                    report_mismatch($sformatf("class_index got %0d want %0d",
                                              o_class_index, head_tile.cls));
                if (o_noise_height !== head_tile.height)
                    report_mismatch($sformatf("noise_height got %0d want %0d",
                                              o_noise_height, head_tile.height));
                if (o_variant_bits !== head_tile.variant)
                    report_mismatch($sformatf("variant_bits got %0d want %0d",
                                              o_variant_bits, head_tile.variant));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving.
    // ------------------------------------------------------------------------

    // Send one tile beat. Idle cycles come first, so start is never dropped
    // and raised in the same step. A pinned class replaces the model's class
    // where the answer is plain by inspection.
    task automatic send_tile(input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y,
                             input bit                 pin_class,
                             input logic [CLASS_W-1:0] pinned_class);
        t_tile_result want;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_tile_x <= x;
        i_tile_y <= y;
        do
            @(posedge i_clk);
        while (busy);
        want = predict_tile(x, y);
        if (pin_class)
            want.cls = pinned_class;
        pending_tiles.push_back(want);
    endtask

    // Stop sending and wait until every pending result beat has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_tiles.size() != 0)
            @(posedge i_clk);
    endtask

    // Registers change only with the pipeline empty. Every tile yields a
    // result, so an empty queue means an idle block. The task then waits with
    // the enable low, so it is low before the next write raises it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_NOISE_SEED)
            seed_shadow = data;
        else if (idx == CFG_SLOT_COUNT)
            slots_shadow = data[SLOT_W-1:0];
        @(posedge i_clk);
    endtask

    // Coordinates for the random part: mostly uniform, a good share spread
    // over every offset inside a cell, and some at the ends of the range.
    function automatic logic [COORD_W-1:0] pick_coord();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return COORD_W'($urandom);
        if (roll < 85)
            return COORD_W'(TILE_CELL * $urandom_range(10921) +
                            $urandom_range(TILE_CELL - 1));
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'd65535;
            2:       return 16'd65532;  // start of the last cell
            default: return 16'd65531;  // last offset of the cell before it
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed part. Right after reset there is one class, and the written
    // values of zero and of 0x001 with junk above bit 8 also mean one class,
    // so the class index there is known to be zero. The rest checks the
    // extremes of both coordinates, a seed of all ones, a class count at and
    // above 256, writes to unmapped indexes, and every offset within a cell.
    // ------------------------------------------------------------------------
    t_step_row directed_steps [31] = '{
        '{ROW_TILE_CLASS, CFG_NOISE_SEED,  32'h0000_0000, 16'd0,     16'd0,     8'd0},
        '{ROW_TILE_CLASS, CFG_NOISE_SEED,  32'h0000_0000, 16'd65535, 16'd65535, 8'd0},
        '{ROW_TILE_CLASS, CFG_NOISE_SEED,  32'h0000_0000, 16'd5,     16'd5,     8'd0},
        '{ROW_TILE_CLASS, CFG_NOISE_SEED,  32'h0000_0000, 16'd6,     16'd11,    8'd0},
        '{ROW_WRITE,      CFG_SLOT_COUNT,  32'h0000_0000, 16'd0,     16'd0,     8'd0},
        '{ROW_TILE_CLASS, CFG_NOISE_SEED,  32'h0000_0000, 16'd12345, 16'd777,   8'd0},
        '{ROW_TILE_CLASS, CFG_NOISE_SEED,  32'h0000_0000, 16'd65535, 16'd0,     8'd0},
        '{ROW_WRITE,      CFG_SLOT_COUNT,  32'hFFFF_FE01, 16'd0,     16'd0,     8'd0},
        '{ROW_TILE_CLASS, CFG_NOISE_SEED,  32'h0000_0000, 16'd0,     16'd65535, 8'd0},
        '{ROW_WRITE,      CFG_NOISE_SEED,  32'hFFFF_FFFF, 16'd0,     16'd0,     8'd0},
        '{ROW_WRITE,      CFG_SLOT_COUNT,  32'd256,       16'd0,     16'd0,     8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd0,     16'd0,     8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd65535, 16'd65535, 8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd0,     16'd65535, 8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd65535, 16'd0,     8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd3,     16'd4,     8'd0},
        '{ROW_WRITE,      CFG_SLOT_COUNT,  32'd511,       16'd0,     16'd0,     8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd40000, 16'd21845, 8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd32768, 16'd32767, 8'd0},
        '{ROW_WRITE,      CFG_UNMAPPED_LO, 32'h0000_0003, 16'd0,     16'd0,     8'd0},
        '{ROW_WRITE,      CFG_UNMAPPED_HI, 32'h0000_0002, 16'd0,     16'd0,     8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd40000, 16'd21845, 8'd0},
        '{ROW_WRITE,      CFG_NOISE_SEED,  32'h1234_5678, 16'd0,     16'd0,     8'd0},
        '{ROW_WRITE,      CFG_SLOT_COUNT,  32'd7,         16'd0,     16'd0,     8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd6,     16'd17,    8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd7,     16'd17,    8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd8,     16'd17,    8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd9,     16'd17,    8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd10,    16'd17,    8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd11,    16'd17,    8'd0},
        '{ROW_TILE,       CFG_NOISE_SEED,  32'h0000_0000, 16'd65534, 16'd65533, 8'd0}
    };

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] seed_word;
        logic [CFG_DATA_W-1:0] slot_word;
        logic [SLOT_W-1:0]     slot_low;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            case (directed_steps[i].kind)
                ROW_WRITE: begin
                    write_reg(directed_steps[i].idx, directed_steps[i].data);
                end
                ROW_TILE_CLASS: begin
                    send_tile(directed_steps[i].x, directed_steps[i].y, 1'b1,
                              directed_steps[i].cls);
                end
                default: begin
                    send_tile(directed_steps[i].x, directed_steps[i].y, 1'b0, '0);
                end
            endcase
        end

        // Random part: each phase picks a seed and a class count, then streams
        // tiles. The first phases pin the extremes of both registers; one
        // phase runs without any idle cycle so beats go in back to back.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       seed_word = 32'h0000_0000;
                1:       seed_word = 32'hFFFF_FFFF;
                default: seed_word = $urandom;
            endcase
            case (ph)
                0:       slot_low = 9'd256;
                1:       slot_low = 9'd1;
                2:       slot_low = 9'd0;
                3:       slot_low = 9'(257 + $urandom_range(254));
                default: slot_low = ($urandom_range(3) == 0) ?
                                    9'($urandom) : 9'($urandom_range(1, 256));
            endcase
            // Bits above the register width are junk the block must drop.
            slot_word = ($urandom & ~32'h1FF) | 32'(slot_low);
            write_reg(CFG_NOISE_SEED, seed_word);
            write_reg(CFG_SLOT_COUNT, slot_word);

            idle_pct = (ph == 3) ? 0 : IDLE_PCT;
            for (int n = 0; n < TILES_PER_PHASE; n++)
                send_tile(pick_coord(), pick_coord(), 1'b0, '0);
        end

        drain_results();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Hard stop, far beyond the slowest correct run; reaching it means the
    // block stopped returning beats.
    initial begin
        #LIMIT_NS;
        $display("tb: done, errors");
        $finish;
    end

endmodule
